// File: hw/rtl/lru_key_value_cache_assert.svh
// Assertion macros for the key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	localparam int MODE_W  = 1;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
	localparam logic [VALUE_W-1:0] MISS_VALUE = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] PUT_VALUE  = '0;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_MATCH   = 4'b0010,
		S_RESOLVE = 4'b0100,
		S_WRITE   = 4'b1000
	} state_t;

	typedef struct packed {
		logic ready;
		logic load;
		logic match;
		logic resolve;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/lkv_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface lkv_req_if;
	logic                           valid;
	logic                           ready;
	logic [lkv_pkg::MODE_W-1:0]     mode;
	logic [lkv_pkg::KEY_W-1:0]      key;
	logic signed [lkv_pkg::VALUE_W-1:0] value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic signed [lkv_pkg::VALUE_W-1:0] read_value;
	logic                           evicted;

	modport source (output valid, output found, output read_value, output evicted, input ready);
	modport sink (input valid, input found, input read_value, input evicted, output ready);
endinterface

// File: hw/rtl/lkv_ctrl.sv
// Sequencing state machine for the key-value cache.
`timescale 1ns / 1ps
module lkv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  lkv_pkg::status_t status,
	output lkv_pkg::cmd_t    cmd
);

	lkv_pkg::state_t state_q;
	lkv_pkg::state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			lkv_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.load  = req_valid;
				if (req_valid) begin
					state_d = lkv_pkg::S_MATCH;
				end
			end
			lkv_pkg::S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = lkv_pkg::S_RESOLVE;
			end
			lkv_pkg::S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = lkv_pkg::S_WRITE;
			end
			lkv_pkg::S_WRITE: begin
				// hold until the result register can take the response
				cmd.commit = status.out_free;
				if (status.out_free) begin
					state_d = lkv_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lkv_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/lkv_dpath.sv
// Entry store, match logic, recency ranks and result register.
`timescale 1ns / 1ps
module lkv_dpath #(
	parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lkv_pkg::cmd_t                      cmd,
	output lkv_pkg::status_t                   status,
	input  logic                               cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]          cfg_data,
	input  logic [lkv_pkg::MODE_W-1:0]         req_mode,
	input  logic [lkv_pkg::KEY_W-1:0]          req_key,
	input  logic signed [lkv_pkg::VALUE_W-1:0] req_value,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic                               rsp_found,
	output logic signed [lkv_pkg::VALUE_W-1:0] rsp_read_value,
	output logic                               rsp_evicted
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CAP_W  = lkv_pkg::CAP_W;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int VAL_W  = lkv_pkg::VALUE_W;
	localparam int KEY_W  = lkv_pkg::KEY_W;

	// request registers
	logic                mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VAL_W-1:0]    value_q;
	logic [KEY_BITS-1:0] key_m;

	// entry state
	logic [KEY_BITS-1:0] keys_q [ENTRIES];
	logic [VAL_W-1:0]    val_mem [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [RANK_W-1:0]   rank_q [ENTRIES];
	logic [CNT_W-1:0]    fill_q;
	logic [CAP_W-1:0]    cap_q;

	// match stage
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] old_vec;
	logic [ENTRIES-1:0] hit_vec_s1;
	logic [ENTRIES-1:0] old_vec_s1;
	logic [CNT_W-1:0]   fill_dec;
	logic [RANK_W-1:0]  oldest_rank;

	// resolve stage
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  old_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [RANK_W-1:0] hit_rank;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  cap_eff;
	logic              full;
	logic              hit_s2;
	logic [IDX_W-1:0]  hit_idx_s2;
	logic [IDX_W-1:0]  old_idx_s2;
	logic [IDX_W-1:0]  free_idx_s2;
	logic [RANK_W-1:0] hit_rank_s2;
	logic              full_s2;
	logic [VAL_W-1:0]  rdata_s2;

	// write stage
	logic              insert;
	logic              evict;
	logic [IDX_W-1:0]  slot;
	logic [IDX_W-1:0]  wr_idx;
	logic [ENTRIES-1:0] valid_d;
	logic [RANK_W-1:0] rank_d [ENTRIES];
	logic [CNT_W-1:0]  fill_d;

	// result register
	logic             out_valid_q;
	logic             found_q;
	logic [VAL_W-1:0] read_value_q;
	logic             evicted_q;

	generate
		if (KEY_BITS <= KEY_W) begin : g_key_trunc
			assign key_m = req_key[KEY_BITS-1:0];
		end else begin : g_key_ext
			assign key_m = {{(KEY_BITS - KEY_W){1'b0}}, req_key};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= req_mode[0];
			key_q   <= key_m;
			value_q <= req_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// Compare every entry; the least recent valid entry holds rank fill - 1.
	assign fill_dec    = fill_q - CNT_W'(1);
	assign oldest_rank = fill_dec[RANK_W-1:0];

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (keys_q[i] == key_q);
			old_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_vec_s1 <= hit_vec;
			old_vec_s1 <= old_vec;
		end
	end

	// Keys are unique among valid entries, so the match vectors are one-hot.
	always_comb begin
		hit_idx  = '0;
		old_idx  = '0;
		hit_rank = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_vec_s1[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (old_vec_s1[i]) begin
				old_idx = old_idx | IDX_W'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// clamp capacity into 1..ENTRIES
	assign cap_ext = CMP_W'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign full = CMP_W'(fill_q) >= cap_eff;

	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			hit_s2      <= |hit_vec_s1;
			hit_idx_s2  <= hit_idx;
			old_idx_s2  <= old_idx;
			free_idx_s2 <= free_idx;
			hit_rank_s2 <= hit_rank;
			full_s2     <= full;
			rdata_s2    <= val_mem[hit_idx];
		end
	end

	assign insert = (mode_q == lkv_pkg::MODE_PUT) && !hit_s2;
	assign evict  = insert && full_s2;
	assign slot   = evict ? old_idx_s2 : free_idx_s2;
	assign wr_idx = hit_s2 ? hit_idx_s2 : slot;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_d[i] = valid_q[i];
			rank_d[i]  = rank_q[i];
			if (hit_s2) begin
				// touch: age only the entries that were more recent
				if (valid_q[i]) begin
					if (IDX_W'(i) == hit_idx_s2) begin
						rank_d[i] = '0;
					end else if (rank_q[i] < hit_rank_s2) begin
						rank_d[i] = rank_q[i] + RANK_W'(1);
					end
				end
			end else if (insert) begin
				if (evict && (IDX_W'(i) == old_idx_s2)) begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end
				if (valid_d[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
				if (IDX_W'(i) == slot) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end
			end
		end
		fill_d = (insert && !evict) ? fill_q + CNT_W'(1) : fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			valid_q <= valid_d;
			fill_q  <= fill_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			keys_q[slot] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (mode_q == lkv_pkg::MODE_PUT)) begin
			val_mem[wr_idx] <= value_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q   <= hit_s2;
			evicted_q <= evict;
			if (mode_q == lkv_pkg::MODE_PUT) begin
				read_value_q <= lkv_pkg::PUT_VALUE;
			end else if (hit_s2) begin
				read_value_q <= rdata_s2;
			end else begin
				read_value_q <= lkv_pkg::MISS_VALUE;
			end
		end
	end

	assign status.out_free = !out_valid_q || rsp_ready;
	assign rsp_valid       = out_valid_q;
	assign rsp_found       = found_q;
	assign rsp_read_value  = read_value_q;
	assign rsp_evicted     = evicted_q;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Requests enter on req: mode 0 is a get, mode 1 a put, each with key and value.
// Every request yields one response on rsp: found, read_value (stored value on a
// get hit, -1 on a get miss, 0 on any put) and evicted (a put pushed out the
// least recent entry). cfg_we/cfg_data write the capacity register; the user
// must write it only while no request is in flight, which the block does not
// enforce. 0 acts as 1 and values above ENTRIES as ENTRIES.
// A request passes three steps after it is accepted to reach the output register: match
// of the key against every entry, resolve of the hit, oldest and free slot with
// the value memory read, then the write-back of ranks, key and value. The next
// request is accepted in the cycle after write-back, so the block takes no new
// request until it is through with the last; only one is in flight at a time.
// If the receiver stalls, the response waits in the output register and the
// write-back of the following request holds until it is taken.
// Reset empties the store, clears all ranks and sets capacity to 16.
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"
module lru_key_value_cache #(
	parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lkv_req_if.sink                   req,
	lkv_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

	lkv_pkg::cmd_t    cmd;
	lkv_pkg::status_t status;

	assign req.ready = cmd.ready;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.status    (status),
		.cmd       (cmd)
	);

	lkv_dpath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.req_mode       (req.mode),
		.req_key        (req.key),
		.req_value      (req.value),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_found      (rsp.found),
		.rsp_read_value (rsp.read_value),
		.rsp_evicted    (rsp.evicted)
	);

	`LKV_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready, "request accepted while another is in flight")
	`LKV_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, rsp.valid, "write-back did not present a response")
	`LKV_ASSERT_IMPL(a_evict_on_miss, clk, arst_n, rsp.valid && rsp.evicted, !rsp.found && rsp.read_value == 0, "eviction flagged on a hit or a get")

endmodule

// File: test/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: directed and random gets and puts.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
	import lkv_pkg::*;

	localparam int SLOTS       = ENTRIES_DEF;
	localparam int TAIL_ITEMS  = 150;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 135;

	typedef enum logic {STEP_REQUEST, STEP_CAPACITY} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [MODE_W-1:0]   mode;
		logic [KEY_W-1:0]    key;
		logic [VALUE_W-1:0]  value;
		logic [CAP_W-1:0]    capacity;
	} step_t;

	typedef struct {
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
	} cache_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	lkv_req_if req_ch ();
	lkv_rsp_if rsp_ch ();

	lru_key_value_cache dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the store
	logic [KEY_W-1:0]   slot_key   [SLOTS];
	logic [VALUE_W-1:0] slot_value [SLOTS];
	logic               slot_live  [SLOTS];
	int                 slot_age   [SLOTS];
	int                 live_count;
	logic [CAP_W-1:0]   cap_reg;

	step_t         script[$];
	cache_result_t due_results[$];
	int            request_total = 0;
	int            sent_count    = 0;
	int            taken_count   = 0;
	int            send_gap      = 0;
	int            stall_left    = 0;
	int            errors        = 0;
	int            cycle_count   = 0;

	function automatic cache_result_t cache_access(logic [MODE_W-1:0] mode,
			logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
		cache_result_t r;
		int hit, oldest, free_slot, room, promote, age, i;
		hit = -1;
		oldest = -1;
		free_slot = -1;
		promote = -1;
		r.found = 1'b0;
		r.read_value = PUT_VALUE;
		r.evicted = 1'b0;
		for (i = 0; i < SLOTS; i++)
			if (hit < 0 && slot_live[i] && slot_key[i] == key)
				hit = i;
		r.found = (hit >= 0);
		if (mode[0] == MODE_GET) begin
			if (hit >= 0) begin
				r.read_value = slot_value[hit];
				promote = hit;
			end else begin
				r.read_value = MISS_VALUE;
			end
		end else if (hit >= 0) begin
			slot_value[hit] = value;
			promote = hit;
		end else begin
			room = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : int'(cap_reg));
			// evict only one entry even if the capacity dropped well below the fill
			if (live_count >= room) begin
				for (i = 0; i < SLOTS; i++)
					if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
						oldest = i;
				if (oldest >= 0) begin
					slot_live[oldest] = 1'b0;
					slot_age[oldest] = 0;
					live_count--;
					r.evicted = 1'b1;
				end
			end
			for (i = 0; i < SLOTS; i++)
				if (free_slot < 0 && !slot_live[i])
					free_slot = i;
			if (free_slot >= 0) begin
				for (i = 0; i < SLOTS; i++)
					if (slot_live[i])
						slot_age[i]++;
				slot_key[free_slot] = key;
				slot_value[free_slot] = value;
				slot_live[free_slot] = 1'b1;
				slot_age[free_slot] = 0;
				live_count++;
			end
		end
		if (promote >= 0) begin
			age = slot_age[promote];
			for (i = 0; i < SLOTS; i++)
				if (slot_live[i] && slot_age[i] < age)
					slot_age[i]++;
			slot_age[promote] = 0;
		end
		return r;
	endfunction

	task automatic add_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
			logic [VALUE_W-1:0] value);
		step_t s;
		s.kind = STEP_REQUEST;
		s.mode = mode;
		s.key = key;
		s.value = value;
		s.capacity = '0;
		script.push_back(s);
		request_total++;
	endtask

	task automatic add_capacity(logic [CAP_W-1:0] capacity);
		step_t s;
		s.kind = STEP_CAPACITY;
		s.mode = MODE_GET;
		s.key = '0;
		s.value = '0;
		s.capacity = capacity;
		script.push_back(s);
	endtask

	// Driver: issue requests and capacity writes from the script
	always @(posedge clk) begin
		step_t head;
		logic  accepted;
		logic  hold_valid;
		logic  write_cap;
		if (arst_n) begin
			accepted = req_ch.valid && req_ch.ready;
			hold_valid = req_ch.valid && !accepted;
			write_cap = 1'b0;
			if (accepted) begin
				due_results.push_back(cache_access(req_ch.mode, req_ch.key, req_ch.value));
				sent_count <= sent_count + 1;
			end
			if (!hold_valid && script.size() > 0) begin
				head = script[0];
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (head.kind == STEP_CAPACITY) begin
					// write only once every request has been answered
					if (!accepted && sent_count == taken_count) begin
						write_cap = 1'b1;
						cfg_data <= head.capacity;
						cap_reg = head.capacity;
						script.delete(0);
					end
				end else if (sent_count + TAIL_ITEMS < request_total
						&& $urandom_range(0, 3) == 0) begin
					send_gap <= $urandom_range(0, 9);
				end else begin
					hold_valid = 1'b1;
					req_ch.mode <= head.mode;
					req_ch.key <= head.key;
					req_ch.value <= head.value;
					script.delete(0);
				end
			end
			req_ch.valid <= hold_valid;
			cfg_we <= write_cap;
		end
	end

	// Monitor: take responses with random stalls and check them in order
	always @(posedge clk) begin
		cache_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				taken_count <= taken_count + 1;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected response found=%0b read_value=%0d evicted=%0b",
						$time, rsp_ch.found, rsp_ch.read_value, rsp_ch.evicted);
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.found !== want.found) begin
						errors++;
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, rsp_ch.found);
					end
					if (rsp_ch.read_value !== want.read_value) begin
						errors++;
						$display("%0t: read_value expected %0d actual %0d",
							$time, want.read_value, rsp_ch.read_value);
					end
					if (rsp_ch.evicted !== want.evicted) begin
						errors++;
						$display("%0t: evicted expected %0b actual %0b",
							$time, want.evicted, rsp_ch.evicted);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (sent_count + TAIL_ITEMS < request_total
					&& $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 9);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0]   pool[$];
		logic [CAP_W-1:0]   phase_caps[$];
		logic [KEY_W-1:0]   k;
		logic [VALUE_W-1:0] v;
		int                 room, n, i;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_GET;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		for (i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end
		live_count = 0;
		cap_reg = CAP_RESET;

		// Directed: empty store, extreme keys and values, update in place
		add_capacity(5'd16);
		add_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		add_request(MODE_PUT, 32'h0000_0000, 32'h7fff_ffff);
		add_request(MODE_PUT, 32'hffff_ffff, 32'h8000_0000);
		add_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		add_request(MODE_GET, 32'hffff_ffff, 32'hffff_ffff);
		add_request(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);
		add_request(MODE_GET, 32'h0000_0000, 32'h5555_5555);
		add_request(MODE_GET, 32'h1234_5678, 32'haaaa_aaaa);
		// zero capacity acts as one; the fill stays above it
		add_capacity(5'd0);
		add_request(MODE_PUT, 32'h0000_0001, 32'h0000_0001);
		add_request(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
		add_request(MODE_PUT, 32'h0000_0002, 32'h0000_0002);
		add_request(MODE_PUT, 32'h0000_0001, 32'h0000_0003);
		add_capacity(5'd31);
		add_request(MODE_PUT, 32'h8000_0000, 32'h1111_1111);
		add_request(MODE_PUT, 32'h7fff_ffff, 32'h2222_2222);
		add_request(MODE_PUT, 32'h5555_5555, 32'h3333_3333);
		add_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
		add_capacity(5'd1);
		add_request(MODE_PUT, 32'haaaa_aaaa, 32'h4444_4444);
		add_request(MODE_PUT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
		add_request(MODE_GET, 32'haaaa_aaaa, 32'h0000_0000);
		add_request(MODE_GET, 32'h0f0f_0f0f, 32'h0000_0000);

		// Random phases over a spread of capacities, keys drawn mostly from a small pool
		phase_caps = {5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8,
			5'($urandom_range(1, 16)), 5'd5, 5'd16};
		foreach (phase_caps[p]) begin
			add_capacity(phase_caps[p]);
			room = (phase_caps[p] == 0) ? 1 :
				((phase_caps[p] > SLOTS) ? SLOTS : int'(phase_caps[p]));
			pool.delete();
			n = $urandom_range(1, room + 8);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: pool.push_back(32'h0000_0000);
					1: pool.push_back(32'hffff_ffff);
					default: pool.push_back($urandom());
				endcase
			end
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 9) == 0)
					k = $urandom();
				else
					k = pool[$urandom_range(0, pool.size() - 1)];
				case ($urandom_range(0, 15))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'hffff_ffff;
					3: v = 32'h0000_0000;
					default: v = $urandom();
				endcase
				add_request($urandom_range(0, 1) ? MODE_PUT : MODE_GET, k, v);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (script.size() > 0 || taken_count != request_total)
			@(posedge clk);
		// allow for a stray response after the last one
		repeat (12) @(posedge clk);
		if (due_results.size() > 0)
			$display("%0t: %0d responses never arrived", $time, due_results.size());
		if (errors == 0 && due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
